// File: hdl/lcar_pkg.sv
`default_nettype none
package lcar_pkg;

  localparam int DATA_BITS = 24;
  localparam int CFG_W     = 24;
  localparam int TOUT_W    = 16;
  localparam int WEIGHT_W  = 25;
  localparam int MAG_W     = (DATA_BITS > CFG_W) ? DATA_BITS : CFG_W;
  localparam int BCNT_W    = $clog2(DATA_BITS + 1);
  localparam int DCNT_W    = $clog2(MAG_W + 1);
  localparam int ADDR_W    = 4;

  localparam logic [CFG_W-1:0]  ZERO_OFFSET_RST   = CFG_W'(0);
  localparam logic [CFG_W-1:0]  SCALE_DIVISOR_RST = CFG_W'(1);
  localparam logic [TOUT_W-1:0] TIMEOUT_MS_RST    = TOUT_W'(2000);
  localparam logic [CFG_W-1:0]  WEIGHT_LIMIT_RST  = CFG_W'(5000);

  localparam logic [MAG_W-1:0]     WEIGHT_MAX = MAG_W'(24'hFFFFFF);
  localparam logic [DATA_BITS-1:0] SIGN_FLIP  = {1'b1, {(DATA_BITS-1){1'b0}}};
  localparam logic [TOUT_W-1:0]    WAIT_SAT   = {TOUT_W{1'b1}};

  typedef enum logic [1:0] {
    REG_ZERO_OFFSET   = 2'd0,
    REG_SCALE_DIVISOR = 2'd1,
    REG_TIMEOUT_MS    = 2'd2,
    REG_WEIGHT_LIMIT  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_SHIFT = 2'd2
  } phase_t;

  typedef enum logic {
    CTL_RUN = 1'b0,
    CTL_DIV = 1'b1
  } ctl_t;

  typedef struct packed {
    logic [CFG_W-1:0]  zero_offset;
    logic [CFG_W-1:0]  scale_divisor;
    logic [TOUT_W-1:0] timeout_ms;
    logic [CFG_W-1:0]  weight_limit;
  } cfg_t;

endpackage
`default_nettype wire

// File: hdl/lcar_cfg_regs.sv
`default_nettype none
module lcar_cfg_regs
  import lcar_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_offset   <= ZERO_OFFSET_RST;
      cfg.scale_divisor <= SCALE_DIVISOR_RST;
      cfg.timeout_ms    <= TIMEOUT_MS_RST;
      cfg.weight_limit  <= WEIGHT_LIMIT_RST;
    end else if (wr) begin
      unique case (idx)
        REG_ZERO_OFFSET:   cfg.zero_offset   <= pwdata[CFG_W-1:0];
        REG_SCALE_DIVISOR: cfg.scale_divisor <= pwdata[CFG_W-1:0];
        REG_TIMEOUT_MS:    cfg.timeout_ms    <= pwdata[TOUT_W-1:0];
        REG_WEIGHT_LIMIT:  cfg.weight_limit  <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ZERO_OFFSET:   prdata = 32'(cfg.zero_offset);
      REG_SCALE_DIVISOR: prdata = 32'(cfg.scale_divisor);
      REG_TIMEOUT_MS:    prdata = 32'(cfg.timeout_ms);
      REG_WEIGHT_LIMIT:  prdata = 32'(cfg.weight_limit);
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/lcar_divider.sv
`default_nettype none
module lcar_divider
  import lcar_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [MAG_W-1:0] dividend,
  input  wire logic [MAG_W-1:0] divisor,
  output logic                  done,
  output logic      [MAG_W-1:0] quotient
);

  logic              busy;
  logic [DCNT_W-1:0] count;
  logic [MAG_W-1:0]  rem;
  logic [MAG_W-1:0]  dvs;
  logic [MAG_W:0]    shifted;
  logic [MAG_W+1:0]  trial;

  // one quotient bit per cycle, restoring
  assign shifted = {rem, quotient[MAG_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + DCNT_W'(1);
        if (count == DCNT_W'(MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[MAG_W+1]) begin
        rem <= trial[MAG_W-1:0];
      end else begin
        rem <= shifted[MAG_W-1:0];
      end
      quotient <= {quotient[MAG_W-2:0], ~trial[MAG_W+1]};
    end
  end

endmodule
`default_nettype wire

// File: hdl/load_cell_adc_reader_unit.sv
// An ordinary tick gives its result in the cycle after it is accepted.
// The tick that finishes a readout runs a bit-serial divider, one quotient bit
// a cycle, and gives its result when the divider is done.
// Throughput: one tick a cycle while the output is taken; no tick is accepted
// while the divider runs.
// Reset: rst (synchronous) returns to idle and loads the register defaults.
`default_nettype none
module load_cell_adc_reader_unit
  import lcar_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,  // start_read, dout_level, ms_strobe
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [31:0]       m_axis_tdata,  // sck_level, weight[24:0], timed_out, busy_res
  output logic                   m_axis_tuser,  // weight_valid
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  cfg_t cfg;

  lcar_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  phase_t               phase, phase_next;
  logic [BCNT_W-1:0]    bit_count, bit_count_next;
  logic [DATA_BITS-1:0] shift_word, shift_word_next;
  logic [TOUT_W-1:0]    wait_count, wait_count_next, wait_inc;
  logic                 clock_high, clock_high_next;
  ctl_t                 ctl, ctl_next;

  logic start_read, dout_level, ms_strobe;
  logic acc, fin, tout;

  assign start_read = s_axis_tdata[0];
  assign dout_level = s_axis_tdata[1];
  assign ms_strobe  = s_axis_tdata[2];

  assign s_axis_tready = (ctl == CTL_RUN) && (!m_axis_tvalid || m_axis_tready);
  assign acc           = s_axis_tvalid & s_axis_tready;
  assign wait_inc      = (wait_count != WAIT_SAT) ? wait_count + TOUT_W'(1) : wait_count;

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_word_next = shift_word;
    wait_count_next = wait_count;
    clock_high_next = clock_high;
    tout            = 1'b0;
    fin             = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (start_read) begin
          phase_next      = PH_WAIT;
          wait_count_next = '0;
        end
      end
      PH_WAIT: begin
        if (!dout_level) begin
          phase_next      = PH_SHIFT;
          bit_count_next  = '0;
          shift_word_next = '0;
          clock_high_next = 1'b0;
        end else if (ms_strobe) begin
          wait_count_next = wait_inc;
          if (wait_inc >= cfg.timeout_ms) begin
            tout       = 1'b1;
            phase_next = PH_IDLE;
          end
        end
      end
      PH_SHIFT: begin
        if (!clock_high) begin
          clock_high_next = 1'b1;
        end else begin
          clock_high_next = 1'b0;
          if (bit_count != BCNT_W'(DATA_BITS)) begin
            shift_word_next = {shift_word[DATA_BITS-2:0], dout_level};
            bit_count_next  = bit_count + BCNT_W'(1);
          end else begin
            fin            = 1'b1;
            phase_next     = PH_IDLE;
            bit_count_next = '0;
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        clock_high_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= '0;
      shift_word <= '0;
      wait_count <= '0;
      clock_high <= 1'b0;
    end else if (acc) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_word <= shift_word_next;
      wait_count <= wait_count_next;
      clock_high <= clock_high_next;
    end
  end

  // offset-binary raw word minus tare, sign split off for the divider
  logic [DATA_BITS-1:0] raw;
  logic [MAG_W:0]       diff;
  logic                 diff_neg, div_neg;
  logic [MAG_W-1:0]     diff_mag, divisor, quotient, q_sat;
  logic                 div_start, div_done;
  logic [WEIGHT_W-1:0]  weight;

  assign raw       = shift_word ^ SIGN_FLIP;
  assign diff      = (MAG_W+1)'(raw) - (MAG_W+1)'(cfg.zero_offset);
  assign diff_neg  = diff[MAG_W];
  assign diff_mag  = diff_neg ? MAG_W'(-diff) : diff[MAG_W-1:0];
  assign divisor   = (cfg.scale_divisor == '0) ? MAG_W'(1) : MAG_W'(cfg.scale_divisor);
  assign div_start = acc & fin;

  lcar_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff_mag),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_neg <= diff_neg;
    end
  end

  assign q_sat = (quotient > WEIGHT_MAX) ? WEIGHT_MAX : quotient;

  always_comb begin
    if (div_neg) begin
      weight = -WEIGHT_W'(q_sat);
    end else if (quotient >= MAG_W'(cfg.weight_limit)) begin
      weight = '0;
    end else begin
      weight = WEIGHT_W'(quotient);
    end
  end

  always_comb begin
    ctl_next = ctl;
    unique case (ctl)
      CTL_RUN: if (div_start) ctl_next = CTL_DIV;
      CTL_DIV: if (div_done) ctl_next = CTL_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= CTL_RUN;
    end else begin
      ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((acc && !fin) || div_done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !fin) begin
      m_axis_tdata <= {4'b0000, (phase_next != PH_IDLE), tout,
                       {WEIGHT_W{1'b0}}, clock_high_next};
      m_axis_tuser <= 1'b0;
    end else if (div_done) begin
      m_axis_tdata <= {4'b0000, 1'b0, 1'b0, weight, 1'b0};
      m_axis_tuser <= 1'b1;
    end
  end

`ifndef SYNTH
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (rst)
    (ctl == CTL_DIV) |-> !s_axis_tready)
    else $error("tick accepted while divider runs");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (ctl == CTL_DIV))
    else $error("divider done outside division");

  a_div_to_result: assert property (@(posedge clk) disable iff (rst)
    div_done |=> (m_axis_tvalid && m_axis_tuser))
    else $error("finished weight not presented");

  a_valid_not_busy: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (!m_axis_tdata[27] && !m_axis_tdata[26]))
    else $error("weight presented with busy or timeout set");
`endif

endmodule
`default_nettype wire

// File: bench/tb.sv
`default_nettype none
module tb;
  import lcar_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  STALL_LIMIT = 3000;
  localparam int  HOLD_CYCLES = 300;
  localparam longint W_SAT    = 16777215;

  typedef struct packed {
    logic                sck;
    logic                weight_valid;
    logic [WEIGHT_W-1:0] weight;
    logic                tout;
    logic                busy;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;  // start_read, dout_level, ms_strobe
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;        // sck_level, weight[24:0], timed_out, busy_res
  logic              m_axis_tuser;        // weight_valid
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  load_cell_adc_reader_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // readout predictor state and register copies
  logic [CFG_W-1:0]     cfg_offset = ZERO_OFFSET_RST;
  logic [CFG_W-1:0]     cfg_scale  = SCALE_DIVISOR_RST;
  logic [TOUT_W-1:0]    cfg_tout   = TIMEOUT_MS_RST;
  logic [CFG_W-1:0]     cfg_limit  = WEIGHT_LIMIT_RST;
  phase_t               rd_phase   = PH_IDLE;
  logic [BCNT_W-1:0]    rd_bits    = '0;
  logic [DATA_BITS-1:0] rd_word    = '0;
  logic [TOUT_W-1:0]    rd_wait    = '0;
  logic                 rd_clk_high = 1'b0;

  logic [2:0]   tick_q[$];
  tick_result_t tick_res_q[$];
  int           ticks_queued = 0;
  int           mismatches   = 0;
  int           src_gap_pct  = 9;
  int           sink_gap_pct = 9;
  logic         hold_req     = 1'b0;
  logic         sink_hold    = 1'b0;
  logic         in_taken     = 1'b0;
  int           stall_cycles = 0;

  function automatic logic [WEIGHT_W-1:0] scaled_weight(logic [DATA_BITS-1:0] word);
    longint raw, diff, dv, w, lim;
    raw  = {40'd0, word ^ SIGN_FLIP};
    diff = raw - longint'({40'd0, cfg_offset});
    dv   = (cfg_scale == '0) ? 64'sd1 : longint'({40'd0, cfg_scale});
    lim  = {40'd0, cfg_limit};
    w    = diff / dv;
    if (w >= lim) w = 0;
    if (w > W_SAT) w = W_SAT;
    if (w < -W_SAT) w = -W_SAT;
    return w[WEIGHT_W-1:0];
  endfunction

  function automatic tick_result_t step_readout(logic start, logic dout, logic strobe);
    tick_result_t r;
    r = '0;
    case (rd_phase)
      PH_IDLE: begin
        if (start) begin
          rd_phase = PH_WAIT;
          rd_wait  = '0;
        end
      end
      PH_WAIT: begin
        if (!dout) begin
          rd_phase    = PH_SHIFT;
          rd_bits     = '0;
          rd_word     = '0;
          rd_clk_high = 1'b0;
        end else if (strobe) begin
          if (rd_wait != WAIT_SAT) rd_wait = rd_wait + 1'b1;
          if (rd_wait >= cfg_tout) begin
            r.tout   = 1'b1;
            rd_phase = PH_IDLE;
          end
        end
      end
      PH_SHIFT: begin
        if (!rd_clk_high) begin
          rd_clk_high = 1'b1;
        end else begin
          rd_clk_high = 1'b0;
          if (rd_bits < DATA_BITS) begin
            rd_word = {rd_word[DATA_BITS-2:0], dout};
            rd_bits = rd_bits + 1'b1;
          end else begin
            r.weight       = scaled_weight(rd_word);
            r.weight_valid = 1'b1;
            rd_phase       = PH_IDLE;
            rd_bits        = '0;
          end
        end
      end
      default: begin
        rd_phase    = PH_IDLE;
        rd_clk_high = 1'b0;
      end
    endcase
    r.sck  = rd_clk_high;
    r.busy = (rd_phase != PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp_val, got_val);
      mismatches++;
    end
  endfunction

  // tick driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
        s_axis_tdata  <= {5'd0, tick_q.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_gap_pct);
    end
  end

  initial begin
    wait (hold_req);
    @(posedge clk);
    sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold = 1'b0;
  end

  // monitor and watchdog
  always @(posedge clk) begin
    tick_result_t exp_r;
    logic         in_fire;
    logic         out_fire;
    in_fire  = !rst && s_axis_tvalid && s_axis_tready;
    out_fire = !rst && m_axis_tvalid && m_axis_tready;
    in_taken <= in_fire;
    if (in_fire) begin
      tick_res_q.push_back(step_readout(s_axis_tdata[0], s_axis_tdata[1], s_axis_tdata[2]));
    end
    if (out_fire) begin
      if (tick_res_q.size() == 0) begin
        $display("%0t: unexpected transaction got %0h user %0b", $time, m_axis_tdata,
                 m_axis_tuser);
        mismatches++;
      end else begin
        exp_r = tick_res_q.pop_front();
        check_field("sck_level", int'(exp_r.sck), int'(m_axis_tdata[0]));
        check_field("weight", int'(exp_r.weight), int'(m_axis_tdata[WEIGHT_W:1]));
        check_field("timed_out", int'(exp_r.tout), int'(m_axis_tdata[WEIGHT_W+1]));
        check_field("busy_res", int'(exp_r.busy), int'(m_axis_tdata[WEIGHT_W+2]));
        check_field("weight_valid", int'(exp_r.weight_valid), int'(m_axis_tuser));
      end
    end
    if (rst || in_fire || out_fire) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ZERO_OFFSET:   cfg_offset = val[CFG_W-1:0];
      REG_SCALE_DIVISOR: cfg_scale  = val[CFG_W-1:0];
      REG_TIMEOUT_MS:    cfg_tout   = val[TOUT_W-1:0];
      REG_WEIGHT_LIMIT:  cfg_limit  = val[CFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] ofs, logic [31:0] scl, logic [31:0] tmo,
                           logic [31:0] lim);
    write_reg(REG_ZERO_OFFSET, ofs);
    write_reg(REG_SCALE_DIVISOR, scl);
    write_reg(REG_TIMEOUT_MS, tmo);
    write_reg(REG_WEIGHT_LIMIT, lim);
  endtask

  // wait for all ticks and results, then let a finishing divide run out
  task automatic settle();
    while (tick_q.size() != 0 || s_axis_tvalid || tick_res_q.size() != 0) @(negedge clk);
    repeat (DATA_BITS + 8) @(negedge clk);
  endtask

  function automatic void queue_tick(bit start, bit dout, bit strobe);
    tick_q.push_back({strobe, dout, start});
    ticks_queued++;
  endfunction

  function automatic logic [DATA_BITS-1:0] pick_word();
    int unsigned          kind;
    int unsigned          span;
    logic [DATA_BITS-1:0] raw;
    kind = $urandom_range(6);
    span = 1 << $urandom_range(22);
    case (kind)
      0: return '0;
      1: return '1;
      2: return SIGN_FLIP;
      3: return ~SIGN_FLIP;
      4: return DATA_BITS'($urandom);
      5: raw = DATA_BITS'(cfg_offset + $urandom_range(2 * span) - span);
      default: raw = DATA_BITS'(cfg_offset + (cfg_limit + $urandom_range(4) - 2) * cfg_scale
                                + $urandom_range(span));
    endcase
    return raw ^ SIGN_FLIP;
  endfunction

  // start, wait for data low, then 24 bit pulses and the gain pulse
  function automatic void queue_readout(int n_wait, logic [DATA_BITS-1:0] word,
                                        int strobe_pct);
    queue_tick(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
    repeat (n_wait) queue_tick($urandom_range(99) < 10, 1'b1, $urandom_range(99) < strobe_pct);
    queue_tick(1'b0, 1'b0, $urandom_range(99) < strobe_pct);
    for (int i = DATA_BITS - 1; i >= 0; i--) begin
      queue_tick(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
      queue_tick(1'b0, word[i], 1'($urandom_range(1)));
    end
    queue_tick(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
    queue_tick(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  task automatic run_phase(int n_items, int strobe_pct, int max_wait);
    int stop_at;
    stop_at = ticks_queued + n_items;
    while (ticks_queued < stop_at) begin
      if ($urandom_range(99) < 12) begin
        repeat ($urandom_range(1, 4)) begin
          queue_tick(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      end else begin
        queue_readout($urandom_range(max_wait), pick_word(), strobe_pct);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // divisor zero, timeout zero, limit zero
    configure(0, 0, 0, 0);
    queue_tick(1'b0, 1'b0, 1'b0);
    queue_tick(1'b0, 1'b1, 1'b1);
    queue_tick(1'b1, 1'b1, 1'b0);
    queue_tick(1'b1, 1'b1, 1'b0);
    queue_tick(1'b0, 1'b1, 1'b1);
    queue_tick(1'b0, 1'b1, 1'b1);
    queue_readout(1, '1, 100);
    queue_readout(0, '0, 100);
    settle();

    src_gap_pct  = 0;
    sink_gap_pct = 0;
    configure(32'h80_0000, 1, 3, 32'hFF_FFFF);
    queue_readout(0, SIGN_FLIP, 0);
    queue_readout(0, ~SIGN_FLIP, 0);
    run_phase(40, 40, 6);
    settle();

    src_gap_pct  = 9;
    sink_gap_pct = 9;
    configure(0, 32'hFF_FFFF, 32'hFFFF, 1);
    run_phase(40, 50, 3);
    settle();

    configure(32'(ZERO_OFFSET_RST), 32'(SCALE_DIVISOR_RST), 32'(TIMEOUT_MS_RST),
              32'(WEIGHT_LIMIT_RST));
    hold_req = 1'b1;
    run_phase(40, 30, 4);
    settle();

    configure(32'hFF_FFFF, 7, 1, 300);
    run_phase(40, 30, 4);
    settle();

    repeat (1) begin
      configure($urandom & 32'hFF_FFFF, 1 + ($urandom & ((1 << $urandom_range(23)) - 1)),
                $urandom_range(1, 6), $urandom & 32'hFF_FFFF);
      run_phase(40, 35, 5);
      settle();
    end

    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
hdl/lcar_pkg.sv
hdl/lcar_cfg_regs.sv
hdl/lcar_divider.sv
hdl/load_cell_adc_reader_unit.sv
bench/tb.sv
